// ===== src/grb_pkg.sv =====
// shared constants, codes and the pixel combine function of the glyph row blitter
// no dependencies; imported by grb_frame_store, glyph_row_blitter_unit and the bench
`timescale 1ns / 1ps
`default_nettype none

package grb_pkg;

   localparam int ROWS          = 128;
   localparam int BYTES_PER_ROW = 30;
   localparam int STORE_SIZE    = ROWS * BYTES_PER_ROW;
   localparam int ADDR_W        = 12;
   localparam int ROW_IDX_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_IDX_W     = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
   localparam int REQ_DATA_W    = 56;
   localparam int RSP_DATA_W    = 8;

   localparam logic OP_BLIT = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      MODE_OR      = 2'd0,
      MODE_CLEAR   = 2'd1,
      MODE_XOR     = 2'd2,
      MODE_REPLACE = 2'd3
   } mode_type;

   // combine one frame byte with ink and cell masks
   function automatic logic [7:0] apply_mode(input logic [7:0] old_byte,
                                             input logic [7:0] ink,
                                             input logic [7:0] cell_bits,
                                             input mode_type mode);
      logic [7:0] res;
      begin
         case (mode)
            MODE_CLEAR:   res = old_byte & ~ink;
            MODE_XOR:     res = old_byte ^ ink;
            MODE_REPLACE: res = (old_byte & ~cell_bits) | ink;
            default:      res = old_byte | ink;
         endcase
         return res;
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/grb_frame_store.sv =====
// frame store memory: one write port, one registered read port
// depends on grb_pkg for depth and address width
`timescale 1ns / 1ps
`default_nettype none

module grb_frame_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [grb_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]                wr_data,
   input  wire logic [grb_pkg::ADDR_W-1:0] rd_addr,
   output logic      [7:0]                rd_data
);
   import grb_pkg::*;

   logic [7:0] mem [STORE_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_addr) < STORE_SIZE)) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (32'(rd_addr) < STORE_SIZE) begin
         rd_data <= mem[rd_addr];
      end else begin
         rd_data <= '0;
      end
   end

endmodule

`default_nettype wire

// ===== src/glyph_row_blitter_unit.sv =====
// glyph row blitter top level: request decode, read-modify-write sequencer, result register
// depends on grb_pkg and grb_frame_store
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  width  handshake            contents
// req_      in         56+1   tvalid/tready        blit or read item, kind in tuser
// rsp_      out        8      tvalid/tready        frame byte for read items
//
// a blit reads byte 0, then writes byte 0 while reading byte 1, then writes byte 1;
// the next item is taken in that last step, so a new item is accepted before a blit is done.
// a read fetches its byte, then loads the output register and returns to idle, where the
// next item is taken; the registered item address and the registered store read set this order.
// after reset the store is swept to zero, one byte a cycle, all 3840 bytes, with req_tready low.
// a read result waits in the output register; a held rsp_ stalls the next read and all items behind it.

module glyph_row_blitter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [9:0] x_pos, [18:10] y_pos, [22:19] row_offset, [30:23] glyph_bits,
   // [34:31] cell_width, [36:35] draw_mode, [48:37] read_addr, [55:49] zero
   input  wire logic [grb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] opcode
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] read_data
   output logic      [grb_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import grb_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RD0   = 5'b00100,
      ST_RD1   = 5'b01000,
      ST_WR1   = 5'b10000
   } state_type;

   // request fields
   logic signed [9:0]  x_pos;
   logic signed [8:0]  y_pos;
   logic [3:0]         row_offset;
   logic [7:0]         glyph_bits;
   logic [3:0]         cell_width;
   logic [1:0]         draw_mode;
   logic [ADDR_W-1:0]  read_addr;

   assign x_pos      = req_tdata[9:0];
   assign y_pos      = req_tdata[18:10];
   assign row_offset = req_tdata[22:19];
   assign glyph_bits = req_tdata[30:23];
   assign cell_width = req_tdata[34:31];
   assign draw_mode  = req_tdata[36:35];
   assign read_addr  = req_tdata[48:37];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               op_read_ff;
   logic [ADDR_W-1:0]  addr0_ff, addr1_ff;
   logic               ok0_ff, ok1_ff;
   logic [15:0]        ink_ff, cell_ff;
   mode_type           mode_ff;
   logic               rd_ok_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff;

   // accept-cycle decode
   logic signed [9:0]  py;
   logic signed [6:0]  col0;
   logic signed [7:0]  col1;
   logic               row_ok;
   logic [3:0]         cw_sat;
   logic [7:0]         cell_mask;
   logic [2:0]         shamt;
   logic [ADDR_W-1:0]  row_base;
   logic               accept;
   logic               rsp_load;

   // memory port
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;

   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_WR1);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      py       = 10'(y_pos) + $signed({6'b0, row_offset});
      row_ok   = !py[9] && (32'(py) < ROWS);
      col0     = x_pos[9:3];                 // floor(x / 8)
      col1     = 8'(col0) + 8'sd1;
      shamt    = x_pos[2:0];
      cw_sat   = (cell_width > 4'd8) ? 4'd8 : cell_width;
      cell_mask = (cw_sat == 4'd0) ? 8'h00 : 8'(8'hFF << (4'd8 - cw_sat));
      row_base = ADDR_W'(py[ROW_IDX_W-1:0] * BYTES_PER_ROW);
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_read_ff <= req_tuser;
         ok0_ff     <= row_ok && !col0[6] && (32'(col0) < BYTES_PER_ROW);
         ok1_ff     <= row_ok && !col1[7] && (32'(col1) < BYTES_PER_ROW);
         addr0_ff   <= (req_tuser == OP_READ) ? read_addr
                                              : row_base + ADDR_W'(col0[COL_IDX_W-1:0]);
         addr1_ff   <= row_base + ADDR_W'(col1[COL_IDX_W-1:0]);
         ink_ff     <= {glyph_bits, 8'h00} >> shamt;
         cell_ff    <= {cell_mask, 8'h00} >> shamt;
         mode_ff    <= mode_type'(draw_mode);
         rd_ok_ff   <= 32'(read_addr) < STORE_SIZE;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (32'(clr_cnt_ff) == STORE_SIZE - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            if (op_read_ff == OP_READ) begin
               // read data is refetched each cycle until the output slot frees
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_WR1;
            end
         end
         ST_WR1: begin
            state_in = accept ? ST_RD0 : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // frame store port mux
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr0_ff;
      wr_data = apply_mode(rd_data, ink_ff[15:8], cell_ff[15:8], mode_ff);
      rd_addr = addr0_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = 8'h00;
         end
         ST_RD1: begin
            if (op_read_ff == OP_BLIT) begin
               wr_en   = ok0_ff;
               rd_addr = addr1_ff;
            end
         end
         ST_WR1: begin
            wr_en   = ok1_ff;
            wr_addr = addr1_ff;
            wr_data = apply_mode(rd_data, ink_ff[7:0], cell_ff[7:0], mode_ff);
         end
         default: begin
            rd_addr = addr0_ff;
         end
      endcase
   end

   grb_frame_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rd_ok_ff ? rd_data : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== bench/tb_glyph_row_blitter_unit.sv =====
// self-checking bench for glyph_row_blitter_unit: directed and random blit and read items
// depends on grb_pkg and the glyph_row_blitter_unit rtl
`timescale 1ns / 1ps

module tb_glyph_row_blitter_unit;
   import grb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;   // reset sweep plus ~1200 items at worst pacing, many times over
   localparam int HOLD_CYCLES = 400;      // long output hold for the back-pressure phase
   localparam int PHASE_ITEMS = 270;
   localparam int TAIL_CYCLES = 20;

   // one input item, fields in bus order
   typedef struct packed {
      logic       opcode;
      logic [9:0] x_pos;
      logic [8:0] y_pos;
      logic [3:0] row_offset;
      logic [7:0] glyph_bits;
      logic [3:0] cell_width;
      mode_type   draw_mode;
      logic [11:0] read_addr;
   } glyph_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_BLIT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   glyph_item_type pending_items[$];
   glyph_item_type offered_item;
   logic [7:0]  expected_bytes[$];
   logic [7:0]  frame_mirror[0:STORE_SIZE-1];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int items_queued   = 0;
   int rows_blitted   = 0;
   int reads_issued   = 0;
   int reads_checked  = 0;
   int error_count    = 0;
   int unsigned cycle_count = 0;

   glyph_row_blitter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // byte address of a pixel row and byte column, -1 when clipped
   function automatic int frame_addr(int py, int cc);
      if (py < 0 || py >= ROWS || cc < 0 || cc >= BYTES_PER_ROW) return -1;
      return py * BYTES_PER_ROW + cc;
   endfunction

   // draw one glyph row into the mirror of the frame store
   function automatic void apply_glyph_row(glyph_item_type it);
      int         x, py, col, sh, cw, a;
      logic [7:0]  cell_byte, ink, cmask, cur;
      logic [15:0] win, cwin;
      x    = $signed(it.x_pos);
      py   = $signed(it.y_pos) + int'(it.row_offset);
      sh   = it.x_pos[2:0];
      col  = x >>> 3;                       // floor division, so negative x keeps its right part
      cw   = (it.cell_width > 4'd8) ? 8 : int'(it.cell_width);
      cell_byte = (cw == 0) ? 8'h00 : 8'hFF << (8 - cw);
      win  = {it.glyph_bits, 8'h00} >> sh;
      cwin = {cell_byte, 8'h00} >> sh;
      for (int b = 0; b < 2; b++) begin
         a = frame_addr(py, col + b);
         if (a >= 0) begin
            ink   = (b == 0) ? win[15:8] : win[7:0];
            cmask = (b == 0) ? cwin[15:8] : cwin[7:0];
            cur   = frame_mirror[a];
            case (it.draw_mode)
               MODE_CLEAR:   cur = cur & ~ink;
               MODE_XOR:     cur = cur ^ ink;
               MODE_REPLACE: cur = (cur & ~cmask) | ink;
               default:      cur = cur | ink;
            endcase
            frame_mirror[a] = cur;
         end
      end
   endfunction

   function automatic void queue_blit(int x, int y, int row, int g, int cw, mode_type mode);
      glyph_item_type it;
      it.opcode     = OP_BLIT;
      it.x_pos      = x[9:0];
      it.y_pos      = y[8:0];
      it.row_offset = row[3:0];
      it.glyph_bits = g[7:0];
      it.cell_width = cw[3:0];
      it.draw_mode  = mode;
      it.read_addr  = 12'($urandom_range(4095));  // ignored by a blit
      pending_items.push_back(it);
      items_queued++;
   endfunction

   function automatic void queue_read(int addr);
      glyph_item_type it;
      it            = glyph_item_type'(50'({$urandom, $urandom}));  // unused fields carry noise
      it.opcode     = OP_READ;
      it.read_addr  = addr[11:0];
      pending_items.push_back(it);
      items_queued++;
   endfunction

   // read back both bytes a glyph row may have touched
   function automatic void queue_readback(int x, int y, int row);
      int a;
      for (int b = 0; b < 2; b++) begin
         a = frame_addr(y + row, (x >>> 3) + b);
         if (a >= 0) queue_read(a);
      end
   endfunction

   function automatic int random_glyph();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return 8'hFF;
      if (pick < 25) return 8'h00;
      return $urandom_range(255);
   endfunction

   // mostly well-formed glyphs and text runs near the store, then read-back, plus noise
   task automatic add_random_items(int n_items);
      int target, kind, x, y, rows, start, g, cw, adv, runs;
      mode_type mode;
      target = items_queued + n_items;
      while (items_queued < target) begin
         kind = $urandom_range(99);
         x    = ($urandom_range(3) != 0) ? $urandom_range(263) - 16 : $urandom_range(1023) - 512;
         y    = ($urandom_range(3) != 0) ? $urandom_range(151) - 16 : $urandom_range(511) - 256;
         cw   = $urandom_range(15);
         mode = mode_type'($urandom_range(3));
         if (kind < 40) begin
            // one glyph, consecutive rows
            rows  = $urandom_range(1, 16);
            start = $urandom_range(16 - rows);
            for (int r = 0; r < rows; r++) queue_blit(x, y, start + r, random_glyph(), cw, mode);
            for (int r = 0; r < rows; r++)
               if ($urandom_range(1) == 1) queue_readback(x, y, start + r);
         end else if (kind < 65) begin
            // text run along one pixel row, cells share bytes
            start = $urandom_range(15);
            runs  = $urandom_range(2, 6);
            for (int k = 0; k < runs; k++) begin
               cw   = $urandom_range(15);
               adv  = (cw > 8) ? 8 : cw;
               queue_blit(x + k * 8, y, start, random_glyph(), cw,
                          mode_type'($urandom_range(3)));
               if ($urandom_range(2) == 0) queue_readback(x + k * 8, y, start);
               x = x + adv - 8;
            end
            queue_readback(x + runs * 8, y, start);
         end else if (kind < 85) begin
            queue_read(($urandom_range(9) != 0) ? $urandom_range(STORE_SIZE - 1)
                                                : $urandom_range(4095, STORE_SIZE));
         end else begin
            queue_blit($urandom_range(1023), $urandom_range(511), $urandom_range(15),
                       $urandom_range(255), $urandom_range(15), mode_type'($urandom_range(3)));
         end
      end
   endtask

   // sender pause: nothing left to send and every read result back
   task automatic wait_for_drain();
      while (pending_items.size() != 0 || req_tvalid || expected_bytes.size() != 0)
         @(negedge clock);
   endtask

   // request driver: holds an item until accepted, predicts at acceptance
   always @(posedge clock) begin : request_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            offer = 1'b0;
            if (offered_item.opcode == OP_READ) begin
               expected_bytes.push_back((offered_item.read_addr < STORE_SIZE) ?
                                        frame_mirror[offered_item.read_addr] : 8'h00);
               reads_issued++;
            end else begin
               apply_glyph_row(offered_item);
               rows_blitted++;
            end
         end
         // idle gaps only fall between items, never on a pending one
         if (!offer && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered_item = pending_items.pop_front();
            offer        = 1'b1;
            req_tdata    <= {7'd0, offered_item.read_addr, offered_item.draw_mode,
                             offered_item.cell_width, offered_item.glyph_bits,
                             offered_item.row_offset, offered_item.y_pos, offered_item.x_pos};
            req_tuser    <= offered_item.opcode;
         end
         req_tvalid <= offer;
      end
   end

   // long output hold, counted here so the monitor just sees hold_left
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_requests != holds_served) begin
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor: compares each accepted byte with the oldest prediction
   always @(posedge clock) begin : result_monitor
      logic [7:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected read_data, expected none actual %02h", $time, rsp_tdata);
            end else begin
               want = expected_bytes.pop_front();
               reads_checked++;
               if (rsp_tdata !== want) begin
                  error_count++;
                  $display("%0t: read_data mismatch, expected %02h actual %02h",
                           $time, want, rsp_tdata);
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_bytes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: cleared store, read limits, clipping, negative x, all modes, width saturation
      queue_read(0);
      queue_read(STORE_SIZE - 1);
      queue_read(STORE_SIZE);
      queue_read(4095);
      queue_blit(0, 0, 0, 8'hFF, 8, MODE_OR);
      queue_blit(1, 0, 0, 8'h5A, 8, MODE_CLEAR);
      queue_read(0);
      queue_read(1);
      queue_blit(3, 1, 0, 8'hA5, 8, MODE_XOR);
      queue_blit(3, 1, 0, 8'h3C, 8, MODE_XOR);    // back to back on the same bytes
      queue_read(31);
      queue_blit(-3, 2, 0, 8'hFF, 8, MODE_OR);    // left part falls off the store
      queue_read(60);
      queue_blit(237, 3, 0, 8'hFF, 4, MODE_OR);   // right byte past the last column
      queue_read(119);
      queue_blit(4, 4, 0, 8'hFF, 8, MODE_OR);
      queue_blit(0, 4, 0, 8'h81, 0, MODE_REPLACE); // empty cell acts as or
      queue_blit(2, 4, 0, 8'h00, 15, MODE_REPLACE); // width saturates at eight
      queue_read(120);
      queue_read(121);
      queue_blit(16, -1, 1, 8'hF0, 8, MODE_OR);   // negative y brought in by the row offset
      queue_blit(8, 120, 15, 8'hFF, 8, MODE_OR);  // row below the store
      queue_blit(8, 112, 15, 8'h81, 8, MODE_OR);  // last row
      queue_blit(-512, -256, 15, 8'hFF, 15, MODE_XOR);
      queue_blit(511, 255, 15, 8'hFF, 15, MODE_REPLACE);
      queue_read(2);
      queue_read((ROWS - 1) * BYTES_PER_ROW + 1);
      wait_for_drain();

      // pacing phases
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 73 : (phase == 3) ? 20 : 0;
         recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 20 : 0;
         add_random_items(PHASE_ITEMS);
         wait_for_drain();
      end

      // output held for a long stretch while reads keep coming, so the input stalls
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests  = hold_requests + 1;
      for (int k = 0; k < 40; k++) begin
         if (k % 4 == 0) queue_blit($urandom_range(239), $urandom_range(127), $urandom_range(15),
                                    random_glyph(), $urandom_range(15),
                                    mode_type'($urandom_range(3)));
         queue_read($urandom_range(STORE_SIZE - 1));
      end
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d glyph rows and %0d frame reads (%0d compared)",
               rows_blitted, reads_issued, reads_checked);
      $display("over four pacing phases and one %0d-cycle output hold", HOLD_CYCLES);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
